>>> hw/rtl/bhpq_pkg.sv
// Shared constants for the binary heap priority queue.
// No dependencies; imported by the top level.
package bhpq_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 10;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXTRACTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic MODE_MAX = 1'b0;

endpackage

>>> hw/rtl/bhpq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/binary_heap_priority_queue.sv
// Binary heap priority queue of signed 32-bit keys, held 1-indexed in one RAM.
// Depends on bhpq_pkg (constants) and bhpq_ram (key store).
//
// Command channel: raise i_start with i_kind and i_key while o_busy is low; the
//   command transfers at that edge. Kind 0 inserts i_key, kind 1 extracts the root.
// Result channel: o_done pulses for one cycle with o_out_key, o_status and
//   o_count. The receiver cannot stall; take the result in that cycle or lose it.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the order bit
//   (0 largest key at root, 1 smallest key at root). Write only while idle.
// Steps from the transfer edge to the strobe; one RAM read port and one
// shared signed compare carry all the work:
//   Insert: the key climbs L levels, a parent read and a compare per level, until it
//   reaches the root or stops below; L is at most 9, as at most 1023 keys are held.
//   Extract: fetch root and filler, then per level the filler sinks: left read,
//   right read and pick (only when a right child exists), move; it ends when it
//   runs out of children or loses the compare.
//   Refused commands (full insert, empty extract) strobe in the cycle after the transfer.
//   o_busy is high until the strobe; a new command may transfer in the strobe cycle.
// Reset: synchronous, active low. Clears the fill count, order bit, done strobe and sequencer;
//   the key store is not cleared, since only written entries are ever read.
module binary_heap_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_kind,
    input  logic signed [bhpq_pkg::KEY_W-1:0] i_key,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data,
    output logic                            o_done,
    output logic signed [bhpq_pkg::KEY_W-1:0] o_out_key,
    output logic [bhpq_pkg::STATUS_W-1:0]   o_status,
    output logic [bhpq_pkg::COUNT_W-1:0]    o_count
);

    import bhpq_pkg::*;

    localparam logic [ADDR_W-1:0] FULL_COUNT = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROOT_ADDR  = ADDR_W'(1);

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_INS_RD   = 10'b0000000010,   // read parent of the hole
        S_INS_CMP  = 10'b0000000100,   // compare new key with parent
        S_EX_TOP   = 10'b0000001000,   // read the root
        S_EX_FILL  = 10'b0000010000,   // read the last key
        S_EX_GRAB  = 10'b0000100000,   // hold the filler
        S_EX_CHILD = 10'b0001000000,   // read left child or finish
        S_EX_LEFT  = 10'b0010000000,   // hold left, read right
        S_EX_RIGHT = 10'b0100000000,   // pick better child
        S_EX_DEC   = 10'b1000000000    // move child up or drop filler
    } t_state;

    t_state r_state, n_state;

    logic                     r_mode;
    logic [ADDR_W-1:0]        r_count, n_count;
    logic [ADDR_W-1:0]        r_pos, n_pos;        // hole position (parent on extract)
    logic [ADDR_W:0]          r_child, n_child;    // one bit wider: may pass the depth
    logic signed [KEY_W-1:0]  r_key, n_key;        // key inserted, root taken on extract
    logic signed [KEY_W-1:0]  r_filler, n_filler;
    logic signed [KEY_W-1:0]  r_best, n_best;
    logic [ADDR_W-1:0]        r_best_idx, n_best_idx;

    logic                     r_done, n_done;
    logic signed [KEY_W-1:0]  r_out_key, n_out_key;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic [ADDR_W-1:0]        r_out_count, n_out_count;

    // RAM ports.
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic signed [KEY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [KEY_W-1:0]         ram_rdata_raw;
    logic signed [KEY_W-1:0]  ram_rdata;

    // Shared compare unit.
    logic signed [KEY_W-1:0]  cmp_a, cmp_b;
    logic                     cmp_beats;

    logic                     accept;
    logic [ADDR_W:0]          count_ext;
    logic [ADDR_W+COUNT_W-1:0] count_wide;

    bhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata_raw)
    );

    assign ram_rdata = $signed(ram_rdata_raw);

    // True when cmp_a belongs strictly above cmp_b in the current order.
    assign cmp_beats = (r_mode == MODE_MAX) ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

    assign accept    = i_start && (r_state == S_IDLE);
    assign count_ext = {1'b0, r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_child     = r_child;
        n_key       = r_key;
        n_filler    = r_filler;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_done      = 1'b0;
        n_out_key   = r_out_key;
        n_status    = r_status;
        n_out_count = r_out_count;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_key;
        ram_raddr   = r_pos;
        cmp_a       = r_key;
        cmp_b       = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_INSERT) begin
                        if (r_count >= FULL_COUNT) begin
                            n_done      = 1'b1;
                            n_out_key   = '0;
                            n_status    = ST_FULL;
                            n_out_count = r_count;
                        end else begin
                            n_count = r_count + ADDR_W'(1);
                            n_pos   = r_count + ADDR_W'(1);
                            n_key   = i_key;
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done      = 1'b1;
                            n_out_key   = '0;
                            n_status    = ST_EMPTY;
                            n_out_count = r_count;
                        end else begin
                            n_pos   = ROOT_ADDR;
                            n_state = S_EX_TOP;
                        end
                    end
                end
            end

            S_INS_RD: begin
                if (r_pos == ROOT_ADDR) begin
                    // Hole reached the root: drop the key in.
                    ram_we      = 1'b1;
                    n_done      = 1'b1;
                    n_out_key   = '0;
                    n_status    = ST_INSERTED;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end else begin
                    ram_raddr = r_pos >> 1;
                    n_state   = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                ram_we = 1'b1;
                if (cmp_beats) begin
                    // Pull the parent down into the hole and climb.
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos >> 1;
                    n_state   = S_INS_RD;
                end else begin
                    n_done      = 1'b1;
                    n_out_key   = '0;
                    n_status    = ST_INSERTED;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end
            end

            S_EX_TOP: begin
                ram_raddr = ROOT_ADDR;
                n_state   = S_EX_FILL;
            end

            S_EX_FILL: begin
                ram_raddr = r_count;
                n_key     = ram_rdata;
                n_count   = r_count - ADDR_W'(1);
                n_child   = (ADDR_W + 1)'(2);
                n_state   = S_EX_GRAB;
            end

            S_EX_GRAB: begin
                n_filler = ram_rdata;
                n_state  = S_EX_CHILD;
            end

            S_EX_CHILD: begin
                if (r_child > count_ext) begin
                    // No child left: the filler settles here.
                    ram_we      = 1'b1;
                    ram_wdata   = r_filler;
                    n_done      = 1'b1;
                    n_out_key   = r_key;
                    n_status    = ST_EXTRACTED;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end else begin
                    ram_raddr = r_child[ADDR_W-1:0];
                    n_state   = S_EX_LEFT;
                end
            end

            S_EX_LEFT: begin
                n_best     = ram_rdata;
                n_best_idx = r_child[ADDR_W-1:0];
                if (r_child < count_ext) begin
                    ram_raddr = r_child[ADDR_W-1:0] + ADDR_W'(1);
                    n_state   = S_EX_RIGHT;
                end else begin
                    n_state = S_EX_DEC;
                end
            end

            S_EX_RIGHT: begin
                // Right child wins only when strictly better; ties keep left.
                cmp_a = ram_rdata;
                cmp_b = r_best;
                if (cmp_beats) begin
                    n_best     = ram_rdata;
                    n_best_idx = r_child[ADDR_W-1:0] + ADDR_W'(1);
                end
                n_state = S_EX_DEC;
            end

            S_EX_DEC: begin
                cmp_a  = r_best;
                cmp_b  = r_filler;
                ram_we = 1'b1;
                if (cmp_beats) begin
                    ram_wdata = r_best;
                    n_pos     = r_best_idx;
                    n_child   = {r_best_idx, 1'b0};
                    n_state   = S_EX_CHILD;
                end else begin
                    ram_wdata   = r_filler;
                    n_done      = 1'b1;
                    n_out_key   = r_key;
                    n_status    = ST_EXTRACTED;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mode  <= MODE_MAX;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_child     <= n_child;
        r_key       <= n_key;
        r_filler    <= n_filler;
        r_best      <= n_best;
        r_best_idx  <= n_best_idx;
        r_out_key   <= n_out_key;
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    // Count port is 10 bits wide whatever the store depth.
    assign count_wide = {{COUNT_W{1'b0}}, r_out_count};

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_out_key = r_out_key;
    assign o_status  = r_status;
    assign o_count   = count_wide[COUNT_W-1:0];

endmodule
